### rtl/sqmm_pkg.sv
// Shared constants, types and helpers for the square matrix multiply unit.
// Depends on nothing; every other file but sqmm_ram imports it.
package sqmm_pkg;

   // Matrix geometry and element format
   localparam int MAX_N      = 64;
   localparam int ELEM_WIDTH = 16;
   localparam int IDX_W      = $clog2(MAX_N);
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int CNT_W      = $clog2(MAX_N + 1);
   localparam int PROD_W     = 2 * ELEM_WIDTH;

   // Fixed field widths of the channels
   localparam int POS_W   = 6;
   localparam int VALUE_W = 16;
   localparam int SUM_W   = 40;
   localparam int SIZE_W  = 7;
   localparam int CMD_W   = 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

   // Request commands
   localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUM_W-1:0]      sum_type;

   // Tag that travels with each multiply-accumulate step
   typedef struct packed {
      logic             vld;
      logic             first_k;
      logic             last_k;
      logic             last_col;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   // Store write from an accepted load request
   typedef struct packed {
      logic              we_a;
      logic              we_b;
      logic [ADDR_W-1:0] addr;
      elem_type          data;
   } ram_wr_type;

   // Status from the multiply-accumulate stage back to the sequencer
   typedef struct packed {
      logic adv;
      logic busy;
   } mac_status_type;

   // Keep the low element bits of a request value, or sign-extend it
   function automatic elem_type to_elem(logic signed [VALUE_W-1:0] v);
      return ELEM_WIDTH'(v);
   endfunction

   // Clamp the configured size into 1..MAX_N
   function automatic logic [CNT_W-1:0] active_size(logic [SIZE_W-1:0] s);
      logic [CNT_W-1:0] n;
      if (s == '0) begin
         n = CNT_W'(1);
      end else if (int'(s) > MAX_N) begin
         n = CNT_W'(MAX_N);
      end else begin
         n = CNT_W'(s);
      end
      return n;
   endfunction

endpackage

### rtl/sqmm_if.sv
// Request and response channel interfaces of the matrix multiply unit.
// Depends on sqmm_pkg for field widths.
interface sqmm_req_if;
   import sqmm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [POS_W-1:0]          row;
   logic [POS_W-1:0]          col;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, cmd, row, col, value, input ready);
   modport sink (input valid, cmd, row, col, value, output ready);
endinterface

interface sqmm_rsp_if;
   import sqmm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [POS_W-1:0]        out_row;
   logic [POS_W-1:0]        out_col;
   logic signed [SUM_W-1:0] product_sum;
   logic                    last;

   modport source (output valid, out_row, out_col, product_sum, last, input ready);
   modport sink (input valid, out_row, out_col, product_sum, last, output ready);
endinterface

### rtl/sqmm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; holds one element store.
module sqmm_ram #(
   parameter int DATA_W = 16,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port, hold data when not reading
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/sqmm_seq.sv
// Sequencer: takes requests, writes loads into the stores and walks the
// (column, k) loop of a row compute, issuing store reads. Depends on sqmm_pkg.
module sqmm_seq (
   input  logic                    clock,
   input  logic                    reset,
   sqmm_req_if.sink                req,
   input  logic [sqmm_pkg::CNT_W-1:0] n,
   input  sqmm_pkg::mac_status_type   mac_st,
   output sqmm_pkg::ram_wr_type       wr,
   output logic                       rd_en,
   output logic [sqmm_pkg::ADDR_W-1:0] a_raddr,
   output logic [sqmm_pkg::ADDR_W-1:0] b_raddr,
   output sqmm_pkg::tag_type          tag
);
   import sqmm_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   tag_type          tag_ff, tag_in;
   logic             accept;
   logic             in_store;
   logic             k_last;
   logic             j_last;
   logic             issue;

   assign accept   = req.valid && req.ready;
   assign in_store = (int'(req.row) < MAX_N) && (int'(req.col) < MAX_N);
   assign k_last   = (CNT_W'(k_ff) == n - CNT_W'(1));
   assign j_last   = (CNT_W'(j_ff) == n - CNT_W'(1));
   assign issue    = (state_ff == ST_ISSUE) && mac_st.adv;

   assign req.ready = (state_ff == ST_IDLE);

   // Load writes go straight to the stores
   always_comb begin
      wr.we_a = accept && in_store && (req.cmd == CMD_LOAD_A);
      wr.we_b = accept && in_store && (req.cmd == CMD_LOAD_B);
      wr.addr = {IDX_W'(req.row), IDX_W'(req.col)};
      wr.data = to_elem(req.value);
   end

   // Read addresses for the current step
   assign rd_en   = issue;
   assign a_raddr = {i_ff, k_ff};
   assign b_raddr = {k_ff, j_ff};
   assign tag     = tag_ff;

   // Advance the loop counters and the state
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      tag_in   = tag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.cmd == CMD_COMPUTE) && (int'(req.row) < int'(n))) begin
               state_in = ST_ISSUE;
               i_in     = IDX_W'(req.row);
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_ISSUE: begin
            if (issue) begin
               if (k_last) begin
                  k_in = '0;
                  if (j_last) begin
                     state_in = ST_DRAIN;
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end else begin
                  k_in = k_ff + IDX_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (!tag_ff.vld && !mac_st.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Tag lines up with the read data of the stores
      if (mac_st.adv) begin
         tag_in.vld      = issue;
         tag_in.first_k  = (k_ff == '0);
         tag_in.last_k   = k_last;
         tag_in.last_col = j_last;
         tag_in.row      = i_ff;
         tag_in.col      = j_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tag_ff.vld <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tag_ff.vld <= tag_in.vld;
      end
      i_ff            <= i_in;
      j_ff            <= j_in;
      k_ff            <= k_in;
      tag_ff.first_k  <= tag_in.first_k;
      tag_ff.last_k   <= tag_in.last_k;
      tag_ff.last_col <= tag_in.last_col;
      tag_ff.row      <= tag_in.row;
      tag_ff.col      <= tag_in.col;
   end

endmodule

### rtl/sqmm_mac.sv
// Multiply-accumulate unit: registered product, running sum and the response
// output register. Depends on sqmm_pkg and sqmm_rsp_if.
module sqmm_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  sqmm_pkg::tag_type         tag,
   input  sqmm_pkg::elem_type        a_data,
   input  sqmm_pkg::elem_type        b_data,
   output sqmm_pkg::mac_status_type  mac_st,
   sqmm_rsp_if.source                rsp
);
   import sqmm_pkg::*;

   tag_type          s2_tag_ff;
   prod_type         prod_ff;
   sum_type          acc_ff, acc_in;
   logic             rsp_valid_ff;
   logic [POS_W-1:0] rsp_row_ff;
   logic [POS_W-1:0] rsp_col_ff;
   sum_type          rsp_sum_ff;
   logic             rsp_last_ff;
   logic             adv;

   // Whole pipeline moves only when the output register can take a result
   assign adv         = !rsp_valid_ff || rsp.ready;
   assign mac_st.adv  = adv;
   assign mac_st.busy = s2_tag_ff.vld;

   // Start a fresh sum on the first k, else add on
   assign acc_in = s2_tag_ff.first_k ? SUM_W'(prod_ff) : acc_ff + SUM_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff.vld <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (adv) begin
         s2_tag_ff.vld <= tag.vld;
         rsp_valid_ff  <= s2_tag_ff.vld && s2_tag_ff.last_k;
      end
      if (adv) begin
         s2_tag_ff.first_k  <= tag.first_k;
         s2_tag_ff.last_k   <= tag.last_k;
         s2_tag_ff.last_col <= tag.last_col;
         s2_tag_ff.row      <= tag.row;
         s2_tag_ff.col      <= tag.col;
         prod_ff            <= a_data * b_data;
         if (s2_tag_ff.vld) begin
            acc_ff <= acc_in;
         end
         // Load the finished column into the output register
         if (s2_tag_ff.vld && s2_tag_ff.last_k) begin
            rsp_row_ff  <= POS_W'(s2_tag_ff.row);
            rsp_col_ff  <= POS_W'(s2_tag_ff.col);
            rsp_sum_ff  <= acc_in;
            rsp_last_ff <= s2_tag_ff.last_col;
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_row     = rsp_row_ff;
   assign rsp.out_col     = rsp_col_ff;
   assign rsp.product_sum = rsp_sum_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

### rtl/square_matrix_multiply_unit.sv
// A load request writes one element of A or B. A compute request for row i
// streams out row i of C, one response per column in order, the last one
// flagged; its multiply-accumulate steps run one after another, set by the
// single MAC unit and the one read port of each element store. Requests are
// taken one at a time; a load or compute may be accepted while the final
// response of a row still waits. Stores are not cleared at reset; each element
// must be loaded before a compute reads it. Write csr_wr_data (matrix size,
// 1..64) only while idle.
module square_matrix_multiply_unit (
   input  logic                        clock,
   input  logic                        reset,
   sqmm_req_if.sink                    req_chan,
   sqmm_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [sqmm_pkg::SIZE_W-1:0] csr_wr_data
);
   import sqmm_pkg::*;

   logic [SIZE_W-1:0] size_ff;
   logic [CNT_W-1:0]  n;
   mac_status_type    mac_st;
   ram_wr_type        wr;
   logic              rd_en;
   logic [ADDR_W-1:0] a_raddr;
   logic [ADDR_W-1:0] b_raddr;
   tag_type           tag;
   elem_type          a_data;
   elem_type          b_data;

   // Size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   assign n = active_size(size_ff);

   sqmm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .n       (n),
      .mac_st  (mac_st),
      .wr      (wr),
      .rd_en   (rd_en),
      .a_raddr (a_raddr),
      .b_raddr (b_raddr),
      .tag     (tag)
   );

   sqmm_ram #(.DATA_W(ELEM_WIDTH), .ADDR_W(ADDR_W)) u_a_store (
      .clock (clock),
      .we    (wr.we_a),
      .waddr (wr.addr),
      .wdata (wr.data),
      .re    (rd_en),
      .raddr (a_raddr),
      .rdata (a_data)
   );

   sqmm_ram #(.DATA_W(ELEM_WIDTH), .ADDR_W(ADDR_W)) u_b_store (
      .clock (clock),
      .we    (wr.we_b),
      .waddr (wr.addr),
      .wdata (wr.data),
      .re    (rd_en),
      .raddr (b_raddr),
      .rdata (b_data)
   );

   sqmm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .tag    (tag),
      .a_data (a_data),
      .b_data (b_data),
      .mac_st (mac_st),
      .rsp    (rsp_chan)
   );

endmodule

### rtl/sqmm_checker.sv
// Port-level checks for square_matrix_multiply_unit, attached by bind.
// Depends on sqmm_pkg for command codes and widths.
module sqmm_port_asserts (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [sqmm_pkg::CMD_W-1:0]     req_cmd,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_last,
   input logic [sqmm_pkg::POS_W-1:0]     rsp_col,
   input logic signed [sqmm_pkg::SUM_W-1:0] rsp_sum
);
   import sqmm_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_col) && $stable(rsp_sum)
         && $stable(rsp_last))
      else $error("stalled response changed");

   // Drop responses on reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A load leaves the request channel ready again in the next cycle
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_LOAD_A || req_cmd == CMD_LOAD_B)
         |=> req_ready)
      else $error("load request did not finish in one cycle");

   // A row still in progress blocks new requests
   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("request taken in the middle of a row");

endmodule

bind square_matrix_multiply_unit sqmm_port_asserts u_sqmm_port_asserts (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_cmd   (req_chan.cmd),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.last),
   .rsp_col   (rsp_chan.out_col),
   .rsp_sum   (rsp_chan.product_sum)
);
